[sv/rtpu_pkg.sv]
// Shared types, constants and helper functions of the radix integer text parser.
`timescale 1ns / 1ps

package rtpu_pkg;

    localparam int VALUE_BITS_DEF = 64;

    // Queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [5:0] RADIX_LIMIT = 6'd36;
    localparam logic [5:0] NOT_DIGIT   = 6'd36;
    localparam logic [5:0] DIGIT_X     = 6'd33;
    localparam logic [5:0] RADIX_AUTO  = 6'd0;
    localparam logic [5:0] RADIX_OCT   = 6'd8;
    localparam logic [5:0] RADIX_DEC   = 6'd10;
    localparam logic [5:0] RADIX_HEX   = 6'd16;

    localparam logic [7:0] CH_TERM  = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BOUNDS  = 2'd2;

    localparam logic [1:0] REG_RADIX  = 2'd0;
    localparam logic [1:0] REG_LOWER  = 2'd1;
    localparam logic [1:0] REG_UPPER  = 2'd2;
    localparam logic [1:0] REG_SIGNED = 2'd3;

    // Classified character as it travels from front to back.
    typedef struct packed {
        logic       term;
        logic       blank;
        logic       plus;
        logic       minus;
        logic [5:0] digit;
    } t_cls;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } t_result;

    function automatic logic radix_ok(input logic [5:0] r);
        return (r == RADIX_AUTO) || (r >= 6'd2 && r <= RADIX_LIMIT);
    endfunction

    function automatic t_cls classify(input logic [7:0] c);
        t_cls k;
        k.term  = (c == CH_TERM);
        k.blank = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        k.plus  = (c == CH_PLUS);
        k.minus = (c == CH_MINUS);
        if (c inside {[8'h30:8'h39]}) begin
            k.digit = 6'(c - 8'h30);
        end else if (c inside {[8'h61:8'h7A]}) begin
            k.digit = 6'(c - 8'h61 + 8'd10);
        end else if (c inside {[8'h41:8'h5A]}) begin
            k.digit = 6'(c - 8'h41 + 8'd10);
        end else begin
            k.digit = NOT_DIGIT;
        end
        return k;
    endfunction

endpackage

[sv/radix_integer_text_parser_unit.sv]
// Radix integer text parser: top level with register port, front, queue and back.
//
// Usage:
//   Characters enter on the s_axis channel, one byte per request; a zero byte
//   ends the string. Each terminator yields one result on m_axis: a 64-bit
//   value and a 2-bit status (0 ok, 1 invalid, 2 out of bounds). Other bytes
//   yield nothing.
//   Registers (radix, lower bound, upper bound, signed mode) sit on the APB
//   port at byte addresses 0, 8, 16, 24; write them only while idle.
//   Throughput: one character per cycle while the queue has room; the digit
//   multiply-accumulate in the back end is combinational.
//   An accepted terminator passes through the queue, then the parse step moves
//   it into the check stage and the bounds check into the output register.
//   When m_axis stalls, the output register holds the result, one more
//   finished string waits in the check stage, and the queue keeps taking
//   characters; s_axis_tready drops only once the queue is full.
//   Reset (synchronous, active low) clears the parse state, the queue and the
//   output valid, and loads radix 10, bounds 0 and all ones, unsigned mode.
`timescale 1ns / 1ps

module radix_integer_text_parser_unit #(
    parameter int VALUE_BITS = rtpu_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] value, [65:64] status, [71:66] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import rtpu_pkg::*;

    logic [5:0]  r_radix;
    logic [63:0] r_lower;
    logic [63:0] r_upper;
    logic        r_signed;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    logic        q_full;
    logic        q_push;
    logic        q_valid;
    logic        q_pop;
    t_cls        f_cls;
    t_cls        q_cls;
    t_result     b_result;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RADIX_DEC;
            r_lower  <= '0;
            r_upper  <= '1;
            r_signed <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RADIX:  r_radix  <= pwdata[5:0];
                REG_LOWER:  r_lower  <= pwdata;
                REG_UPPER:  r_upper  <= pwdata;
                REG_SIGNED: r_signed <= pwdata[0];
                default:    r_signed <= r_signed;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RADIX:  prdata = 64'(r_radix);
            REG_LOWER:  prdata = r_lower;
            REG_UPPER:  prdata = r_upper;
            REG_SIGNED: prdata = 64'(r_signed);
            default:    prdata = '0;
        endcase
    end

    rtpu_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cls    (f_cls)
    );

    rtpu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_cls),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cls),
        .i_pop   (q_pop)
    );

    rtpu_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cls    (q_cls),
        .o_pop    (q_pop),
        .i_radix  (r_radix),
        .i_lower  (r_lower),
        .i_upper  (r_upper),
        .i_signed (r_signed),
        .o_valid  (m_axis_tvalid),
        .o_result (b_result),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, b_result.status, b_result.value};

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("back end pops an empty queue");

    a_value_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[65:64] != ST_OK) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("nonzero value with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[65:64] == ST_OK ||
                           m_axis_tdata[65:64] == ST_INVALID ||
                           m_axis_tdata[65:64] == ST_BOUNDS))
        else $error("undefined status code");
`endif

endmodule

[sv/rtpu_front.sv]
// Front end: input handshake and character classification into the queue.
`timescale 1ns / 1ps

module rtpu_front (
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic [7:0]    i_tdata,
    input  logic          i_q_full,
    output logic          o_push,
    output rtpu_pkg::t_cls o_cls
);
    import rtpu_pkg::*;

    assign o_tready = !i_q_full;
    assign o_push   = i_tvalid && !i_q_full;
    assign o_cls    = classify(i_tdata);

endmodule

[sv/rtpu_queue.sv]
// Short queue of classified characters between front and back.
`timescale 1ns / 1ps

module rtpu_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rtpu_pkg::t_cls i_data,
    output logic           o_full,
    output logic           o_valid,
    output rtpu_pkg::t_cls o_data,
    input  logic           i_pop
);
    import rtpu_pkg::*;

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

[sv/rtpu_back.sv]
// Back end: parse state machine, digit accumulate, finish check and result register.
`timescale 1ns / 1ps

module rtpu_back #(
    parameter int VALUE_BITS = rtpu_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rtpu_pkg::t_cls    i_cls,
    output logic              o_pop,
    input  logic [5:0]        i_radix,
    input  logic [63:0]       i_lower,
    input  logic [63:0]       i_upper,
    input  logic              i_signed,
    output logic              o_valid,
    output rtpu_pkg::t_result o_result,
    input  logic              i_ready
);
    import rtpu_pkg::*;

    localparam int PW = VALUE_BITS + 6;
    localparam logic [VALUE_BITS-1:0] MAG_MAX    = '1;
    localparam logic [VALUE_BITS-1:0] SIGNED_MAX = MAG_MAX >> 1;

    localparam logic [2:0] PH_LEAD   = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_PREFIX = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_TRAIL  = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    logic [2:0]            r_phase,  n_phase;
    logic [VALUE_BITS-1:0] r_acc,    n_acc;
    logic                  r_neg,    n_neg;
    logic                  r_ovf,    n_ovf;
    logic [5:0]            r_active, n_active;
    logic                  r_lz,     n_lz;

    logic                  r_fin_valid;
    logic                  r_fin_bad;
    logic [63:0]           r_fin_v;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  out_free;
    logic                  fin_adv;
    logic                  fin_free;
    logic                  take;
    logic                  take_term;
    logic                  start;
    logic [5:0]            cand;
    logic [PW-1:0]         prod;
    logic                  prod_ovf;
    logic [VALUE_BITS-1:0] lim;
    logic [63:0]           acc64;
    logic [63:0]           v;
    logic                  sub_bad;
    logic [63:0]           flip;
    logic [63:0]           lo;
    logic [63:0]           hi;
    logic [63:0]           k;
    t_result               res;

    assign out_free  = !r_out_valid || i_ready;
    assign fin_adv   = r_fin_valid && out_free;
    assign fin_free  = !r_fin_valid || fin_adv;
    assign take      = i_valid && (!i_cls.term || fin_free);
    assign take_term = take && i_cls.term;
    assign o_pop     = take;

    assign cand     = (i_radix == RADIX_AUTO) ? RADIX_DEC : i_radix;
    assign prod     = PW'(r_acc) * PW'(r_active) + PW'(i_cls.digit);
    assign prod_ovf = |prod[PW-1:VALUE_BITS];

    // finish, part one: sign handling, syntax and overflow check on the accumulated magnitude
    assign lim     = SIGNED_MAX + VALUE_BITS'(r_neg);
    assign acc64   = 64'(r_acc);
    assign v       = r_neg ? (64'd0 - acc64) : acc64;
    assign sub_bad = !(r_phase == PH_DIGITS || r_phase == PH_TRAIL) || r_ovf ||
                     (i_signed ? (r_acc > lim) : r_neg);

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_ovf    = r_ovf;
        n_active = r_active;
        n_lz     = r_lz;
        start    = 1'b0;
        if (take_term) begin
            n_phase  = PH_LEAD;
            n_acc    = '0;
            n_neg    = 1'b0;
            n_ovf    = 1'b0;
            n_active = '0;
            n_lz     = 1'b0;
        end else if (take) begin
            case (r_phase)
                PH_LEAD: begin
                    if (i_cls.blank) begin
                        n_phase = PH_LEAD;
                    end else if (i_cls.plus) begin
                        n_phase = PH_SIGN;
                    end else if (i_cls.minus) begin
                        if (i_signed) begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGN;
                        end else begin
                            n_phase = PH_ERROR;
                        end
                    end else begin
                        start = 1'b1;
                    end
                end
                PH_SIGN: start = 1'b1;
                PH_PREFIX: begin
                    if (i_cls.digit < RADIX_HEX) begin
                        n_acc   = VALUE_BITS'(i_cls.digit);
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_DIGITS: begin
                    if (i_cls.blank) begin
                        n_phase = PH_TRAIL;
                    end else if (r_lz && i_cls.digit == DIGIT_X) begin
                        n_active = RADIX_HEX;
                        n_lz     = 1'b0;
                        n_phase  = PH_PREFIX;
                    end else if (i_cls.digit < r_active) begin
                        n_lz = 1'b0;
                        if (r_ovf || prod_ovf) begin
                            n_ovf = 1'b1;
                            n_acc = '0;
                        end else begin
                            n_acc = prod[VALUE_BITS-1:0];
                        end
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_TRAIL: begin
                    if (!i_cls.blank) n_phase = PH_ERROR;
                end
                default: n_phase = PH_ERROR;
            endcase

            if (start) begin
                n_acc = '0;
                if (!radix_ok(i_radix)) begin
                    n_phase = PH_ERROR;
                end else if (i_cls.digit == '0 &&
                             (i_radix == RADIX_AUTO || i_radix == RADIX_HEX)) begin
                    n_active = (i_radix == RADIX_AUTO) ? RADIX_OCT : RADIX_HEX;
                    n_lz     = 1'b1;
                    n_phase  = PH_DIGITS;
                end else begin
                    n_active = cand;
                    if (i_cls.digit >= cand) begin
                        n_phase = PH_ERROR;
                    end else begin
                        n_acc   = VALUE_BITS'(i_cls.digit);
                        n_phase = PH_DIGITS;
                    end
                end
            end
        end
    end

    // finish, part two: settings and bounds
    always_comb begin
        flip = {i_signed, 63'd0};
        lo   = i_lower ^ flip;
        hi   = i_upper ^ flip;
        k    = r_fin_v ^ flip;
        res.value = '0;
        if (!radix_ok(i_radix) || lo > hi || r_fin_bad) begin
            res.status = ST_INVALID;
        end else if (k < lo || k > hi) begin
            res.status = ST_BOUNDS;
        end else begin
            res.status = ST_OK;
            res.value  = r_fin_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_ovf       <= 1'b0;
            r_active    <= '0;
            r_lz        <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_ovf    <= n_ovf;
            r_active <= n_active;
            r_lz     <= n_lz;
            if (take_term) begin
                r_fin_valid <= 1'b1;
            end else if (fin_adv) begin
                r_fin_valid <= 1'b0;
            end
            if (fin_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_term) begin
            r_fin_bad <= sub_bad;
            r_fin_v   <= v;
        end
        if (fin_adv) begin
            r_out <= res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
